>>> hdl/dfp_pkg.sv
// ----------------------------------------------------------------------------
// dfp_pkg: shared types and constants for the download frame parser
// Frame header codes, result kinds, the result word type and the
// Modbus CRC-16 byte update.
// ----------------------------------------------------------------------------
package dfp_pkg;

   // frame header bytes
   localparam logic [7:0] HDR_DATA   = 8'hAA;
   localparam logic [7:0] HDR_START  = 8'hAB;
   localparam logic [7:0] HDR_END    = 8'hAC;
   localparam logic [7:0] CMD_SECOND = 8'h01;

   // CRC-16 (Modbus, reflected)
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // header / skip field lengths
   localparam logic [7:0] INDEX_BYTES = 8'd3;
   localparam logic [7:0] SKIP_BYTES  = 8'd3;

   // frame type codes
   localparam logic [1:0] FT_NONE  = 2'd0;
   localparam logic [1:0] FT_START = 2'd1;
   localparam logic [1:0] FT_END   = 2'd2;
   localparam logic [1:0] FT_DATA  = 2'd3;

   // result kind codes
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_START   = 3'd1;
   localparam logic [2:0] KIND_END     = 3'd2;
   localparam logic [2:0] KIND_ACCEPT  = 3'd3;
   localparam logic [2:0] KIND_ORDER   = 3'd4;
   localparam logic [2:0] KIND_CRCERR  = 3'd5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [23:0] block_index;
      logic [7:0]  block_length;
   } rsp_word_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } out_status_type;

   // one byte through the CRC: eight shift steps on 16 bits
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/dfp_if.sv
// ----------------------------------------------------------------------------
// dfp_if: valid/ready channels of the download frame parser
// Request channel carries received bytes, response channel carries results.
// ----------------------------------------------------------------------------
interface dfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [23:0] block_index;
   logic [7:0]  block_length;

   modport source (output valid, output kind, output data_byte, output block_index,
                   output block_length, input ready);
   modport sink   (input valid, input kind, input data_byte, input block_index,
                   input block_length, output ready);
endinterface

>>> hdl/dfp_parser.sv
// ----------------------------------------------------------------------------
// dfp_parser: frame state machine and CRC check
// Consumes one byte per accept, updates frame state, flags a result word.
// ----------------------------------------------------------------------------
module dfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output logic                  result_valid,
   output dfp_pkg::rsp_word_type result
);

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_CMD2    = 4'd1,
      PH_CRCHI   = 4'd2,
      PH_CRCLO   = 4'd3,
      PH_INDEX   = 4'd4,
      PH_SKIP    = 4'd5,
      PH_LEN     = 4'd6,
      PH_PAYLOAD = 4'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  ftype_ff, ftype_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [23:0] index_ff, index_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [23:0] expect_ff, expect_in;

   logic [7:0]  count_inc;
   logic [15:0] crc_step;
   logic [15:0] rx_crc;
   logic        do_hunt;

   assign count_inc = count_ff + 8'd1;
   assign crc_step  = dfp_pkg::crc_byte(crc_ff, rx_byte);
   assign rx_crc    = {crc_high_ff, rx_byte};

   always_comb begin
      phase_in     = phase_ff;
      ftype_in     = ftype_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      index_in     = index_ff;
      length_in    = length_ff;
      crc_high_in  = crc_high_ff;
      expect_in    = expect_ff;
      do_hunt      = 1'b0;
      result_valid = 1'b0;
      result       = '0;

      case (phase_ff)
         PH_CMD2: begin
            if (rx_byte == dfp_pkg::CMD_SECOND) begin
               crc_in   = crc_step;
               phase_in = PH_CRCHI;
            end else begin
               do_hunt = 1'b1;   // re-examine this byte as a header
            end
         end
         PH_INDEX: begin
            crc_in   = crc_step;
            index_in = {index_ff[15:0], rx_byte};
            count_in = count_inc;
            if (count_inc >= dfp_pkg::INDEX_BYTES) begin
               count_in = 8'd0;
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            crc_in   = crc_step;
            count_in = count_inc;
            if (count_inc >= dfp_pkg::SKIP_BYTES) begin
               count_in = 8'd0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            crc_in    = crc_step;
            length_in = rx_byte;
            count_in  = 8'd0;
            phase_in  = (rx_byte == 8'd0) ? PH_CRCHI : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            crc_in   = crc_step;
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = PH_CRCHI;
            end
            result_valid     = 1'b1;
            result.kind      = dfp_pkg::KIND_PAYLOAD;
            result.data_byte = rx_byte;
         end
         PH_CRCHI: begin
            crc_high_in = rx_byte;
            phase_in    = PH_CRCLO;
         end
         PH_CRCLO: begin
            phase_in     = PH_HUNT;
            count_in     = 8'd0;
            result_valid = 1'b1;
            if (ftype_ff == dfp_pkg::FT_DATA) begin
               result.block_index  = index_ff;
               result.block_length = length_ff;
               if (rx_crc != crc_ff) begin
                  result.kind = dfp_pkg::KIND_CRCERR;
               end else if (index_ff == expect_ff) begin
                  expect_in   = expect_ff + {16'd0, length_ff};
                  result.kind = dfp_pkg::KIND_ACCEPT;
               end else begin
                  result.kind = dfp_pkg::KIND_ORDER;
               end
            end else if (rx_crc != crc_ff) begin
               result.kind = dfp_pkg::KIND_CRCERR;
            end else if (ftype_ff == dfp_pkg::FT_START) begin
               result.kind = dfp_pkg::KIND_START;
            end else begin
               result.kind = dfp_pkg::KIND_END;
            end
         end
         default: begin
            do_hunt = 1'b1;
         end
      endcase

      if (do_hunt) begin
         phase_in = PH_HUNT;
         if (rx_byte == dfp_pkg::HDR_DATA || rx_byte == dfp_pkg::HDR_START ||
             rx_byte == dfp_pkg::HDR_END) begin
            crc_in      = dfp_pkg::crc_byte(dfp_pkg::CRC_INIT, rx_byte);
            count_in    = 8'd0;
            index_in    = 24'd0;
            length_in   = 8'd0;
            crc_high_in = 8'd0;
            if (rx_byte == dfp_pkg::HDR_DATA) begin
               ftype_in = dfp_pkg::FT_DATA;
               phase_in = PH_INDEX;
            end else begin
               ftype_in = (rx_byte == dfp_pkg::HDR_START) ? dfp_pkg::FT_START
                                                          : dfp_pkg::FT_END;
               phase_in = PH_CMD2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         ftype_ff    <= dfp_pkg::FT_NONE;
         count_ff    <= 8'd0;
         crc_ff      <= dfp_pkg::CRC_INIT;
         index_ff    <= 24'd0;
         length_ff   <= 8'd0;
         crc_high_ff <= 8'd0;
         expect_ff   <= 24'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         ftype_ff    <= ftype_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         index_ff    <= index_in;
         length_ff   <= length_in;
         crc_high_ff <= crc_high_in;
         expect_ff   <= expect_in;
      end
   end

endmodule

>>> hdl/dfp_out_stage.sv
// ----------------------------------------------------------------------------
// dfp_out_stage: result register with skid entry
// Holds result words for the response channel; input side stays open
// while one word waits.
// ----------------------------------------------------------------------------
module dfp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dfp_pkg::rsp_word_type   push_word,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dfp_pkg::rsp_word_type   out_word,
   output dfp_pkg::out_status_type status
);

   logic                  main_valid_ff;
   logic                  skid_valid_ff;
   dfp_pkg::rsp_word_type main_ff;
   dfp_pkg::rsp_word_type skid_ff;

   assign in_ready          = !skid_valid_ff;
   assign out_valid         = main_valid_ff;
   assign out_word          = main_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_ready) begin
         main_ff <= skid_valid_ff ? skid_ff : push_word;
      end else if (push) begin
         skid_ff <= push_word;
      end
   end

endmodule

>>> hdl/download_frame_parser_top.sv
// ----------------------------------------------------------------------------
// download_frame_parser_top: framed download parser with CRC-16 check
// Parses start, end and data-block frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries one received serial byte per word (rx_byte).
//  - rsp_if carries zero or one result word per byte: payload bytes as they
//    arrive, then start/end/accept/out-of-order/crc-error at frame end.
//  - A byte is taken on any cycle with req_if.valid and req_if.ready high;
//    one byte per cycle sustained while req_if.ready is high, with the CRC
//    byte update and field capture done for each byte in the parser.
//  - Each result word is registered in the output stage before rsp_if shows it.
//  - When the receiver stalls, one result waits in the output register and
//    a second in a skid entry; req_if.ready drops only while the skid entry
//    is full, so no word is lost or repeated.
//  - Reset (synchronous, active high) puts the parser in header hunt with
//    CRC 0xFFFF and expected block index zero, and empties the output.
//  - After any failure the parser hunts for the next header byte.
// ----------------------------------------------------------------------------
module download_frame_parser_top (
   input  logic      clock,
   input  logic      reset,
   dfp_req_if.sink   req_if,
   dfp_rsp_if.source rsp_if
);

   logic                    accept;
   logic                    result_valid;
   logic                    stage_ready;
   dfp_pkg::rsp_word_type   result;
   dfp_pkg::rsp_word_type   out_word;
   dfp_pkg::out_status_type out_status;

   // byte handshake
   assign accept       = req_if.valid && stage_ready;
   assign req_if.ready = stage_ready;

   dfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_if.rx_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   // result words go to the registered output with skid
   dfp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && result_valid),
      .push_word (result),
      .in_ready  (stage_ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (out_word),
      .status    (out_status)
   );

   assign rsp_if.kind         = out_word.kind;
   assign rsp_if.data_byte    = out_word.data_byte;
   assign rsp_if.block_index  = out_word.block_index;
   assign rsp_if.block_length = out_word.block_length;

   // skid entry only fills behind a full output register
   a_skid_behind_main : assert property (@(posedge clock) disable iff (reset)
      out_status.skid_valid |-> out_status.main_valid)
      else $error("skid entry valid with empty output register");

   // input side blocked only while a result is pending
   a_stall_has_cause : assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("input stalled with no pending result");

   // a byte that yields a result leaves rsp_if.valid high on the next cycle
   a_result_shows : assert property (@(posedge clock) disable iff (reset)
      (accept && result_valid) |=> rsp_if.valid)
      else $error("result word lost after accepted byte");

   // only defined result kinds leave the block
   a_kind_range : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.kind <= dfp_pkg::KIND_CRCERR))
      else $error("undefined result kind");

endmodule

>>> dv/tb_download_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_download_frame_parser_top: self-checking bench for the frame parser
// Feeds start, end and data-block frames (good, corrupted, out of order,
// truncated) mixed with line noise, predicts every result word in a
// scoreboard and checks the result channel against it under random stalls.
// ----------------------------------------------------------------------------
module tb_download_frame_parser_top;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_BYTES  = 650;

   // ---------------------------------------------------------------------
   // Scoreboard: tracks parser state, predicts result words, checks them
   // ---------------------------------------------------------------------
   class frame_scoreboard;
      typedef enum logic [3:0] {
         PH_HUNT, PH_CMD2, PH_CRC_HI, PH_CRC_LO,
         PH_INDEX, PH_SKIP, PH_LEN, PH_PAYLOAD
      } parse_phase_type;

      parse_phase_type       phase;
      logic [1:0]            frame_type;
      logic [7:0]            byte_count;
      logic [15:0]           crc;
      logic [23:0]           index_accum;
      logic [7:0]            length_reg;
      logic [7:0]            crc_high;
      logic [23:0]           expected_index;
      dfp_pkg::rsp_word_type expected_words[$];
      int unsigned           errors;

      // Modbus CRC-16, LSB first, one byte
      static function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
         logic [15:0] c;
         c = c_in ^ {8'h00, b};
         repeat (8) c = c[0] ? ((c >> 1) ^ dfp_pkg::CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void clear();
         phase          = PH_HUNT;
         frame_type     = dfp_pkg::FT_NONE;
         byte_count     = '0;
         crc            = dfp_pkg::CRC_INIT;
         index_accum    = '0;
         length_reg     = '0;
         crc_high       = '0;
         expected_index = '0;
         errors         = 0;
         expected_words.delete();
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // header search; also used when a command's second byte is wrong
      function void start_hunt(logic [7:0] b);
         phase = PH_HUNT;
         if (b == dfp_pkg::HDR_DATA || b == dfp_pkg::HDR_START ||
             b == dfp_pkg::HDR_END) begin
            crc         = crc_step(dfp_pkg::CRC_INIT, b);
            byte_count  = '0;
            index_accum = '0;
            length_reg  = '0;
            crc_high    = '0;
            if (b == dfp_pkg::HDR_DATA) begin
               frame_type = dfp_pkg::FT_DATA;
               phase      = PH_INDEX;
            end else begin
               frame_type = (b == dfp_pkg::HDR_START) ? dfp_pkg::FT_START
                                                      : dfp_pkg::FT_END;
               phase      = PH_CMD2;
            end
         end
      endfunction

      // one accepted byte
      function void note_byte(logic [7:0] b);
         dfp_pkg::rsp_word_type w;
         logic [15:0]           rx_crc;
         bit                    has_word;
         w        = '0;
         has_word = 1'b0;
         case (phase)
            PH_CMD2: begin
               if (b == dfp_pkg::CMD_SECOND) begin
                  crc   = crc_step(crc, b);
                  phase = PH_CRC_HI;
               end else begin
                  start_hunt(b);
               end
            end
            PH_INDEX: begin
               crc         = crc_step(crc, b);
               index_accum = {index_accum[15:0], b};
               byte_count  = byte_count + 8'd1;
               if (byte_count >= dfp_pkg::INDEX_BYTES) begin
                  byte_count = '0;
                  phase      = PH_SKIP;
               end
            end
            PH_SKIP: begin
               crc        = crc_step(crc, b);
               byte_count = byte_count + 8'd1;
               if (byte_count >= dfp_pkg::SKIP_BYTES) begin
                  byte_count = '0;
                  phase      = PH_LEN;
               end
            end
            PH_LEN: begin
               crc        = crc_step(crc, b);
               length_reg = b;
               byte_count = '0;
               phase      = (b == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               crc        = crc_step(crc, b);
               byte_count = byte_count + 8'd1;
               if (byte_count >= length_reg) phase = PH_CRC_HI;
               w.kind      = dfp_pkg::KIND_PAYLOAD;
               w.data_byte = b;
               has_word    = 1'b1;
            end
            PH_CRC_HI: begin
               crc_high = b;
               phase    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               rx_crc     = {crc_high, b};
               phase      = PH_HUNT;
               byte_count = '0;
               has_word   = 1'b1;
               if (frame_type == dfp_pkg::FT_DATA) begin
                  w.block_index  = index_accum;
                  w.block_length = length_reg;
                  if (rx_crc != crc) begin
                     w.kind = dfp_pkg::KIND_CRCERR;
                  end else if (index_accum == expected_index) begin
                     expected_index = expected_index + {16'd0, length_reg};
                     w.kind = dfp_pkg::KIND_ACCEPT;
                  end else begin
                     w.kind = dfp_pkg::KIND_ORDER;
                  end
               end else if (rx_crc != crc) begin
                  w.kind = dfp_pkg::KIND_CRCERR;
               end else begin
                  w.kind = (frame_type == dfp_pkg::FT_START) ? dfp_pkg::KIND_START
                                                             : dfp_pkg::KIND_END;
               end
            end
            default: start_hunt(b);
         endcase
         if (has_word) expected_words.push_back(w);
      endfunction

      function void flag(string why, dfp_pkg::rsp_word_type want,
                         dfp_pkg::rsp_word_type got);
         errors++;
         if (errors <= 10)
            $display("%0t %s: exp kind=%0d data=%02h idx=%06h len=%0d | %s",
                     $realtime, why, want.kind, want.data_byte, want.block_index,
                     want.block_length,
                     $sformatf("got kind=%0d data=%02h idx=%06h len=%0d",
                               got.kind, got.data_byte, got.block_index,
                               got.block_length));
      endfunction

      // one accepted result word
      function void check_word(dfp_pkg::rsp_word_type got);
         dfp_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            flag("unexpected word", '0, got);
            return;
         end
         want = expected_words.pop_front();
         if (got.kind != want.kind || got.data_byte != want.data_byte ||
             got.block_index != want.block_index ||
             got.block_length != want.block_length)
            flag("mismatch", want, got);
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, channels, block
   // ---------------------------------------------------------------------
   logic clock;
   logic reset;

   dfp_req_if req_if ();
   dfp_rsp_if rsp_if ();

   download_frame_parser_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   frame_scoreboard sb;
   int              req_idle_pct = 22;   // sender gap chance per word
   int              rsp_idle_pct = 84;   // receiver stall chance per cycle

   // ---------------------------------------------------------------------
   // Frame builder. Frames are assembled in frame_buf, then appended to
   // the byte stream. next_index shadows the block index the parser wants.
   // ---------------------------------------------------------------------
   logic [7:0]  stim_bytes[$];
   logic [7:0]  frame_buf[$];
   logic [23:0] next_index;

   // any byte that can't open a frame
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == dfp_pkg::HDR_DATA || b == dfp_pkg::HDR_START ||
             b == dfp_pkg::HDR_END);
      return b;
   endfunction

   // append CRC (high byte first), optionally with one bit flipped
   function automatic void seal_frame(bit corrupt);
      logic [15:0] c;
      c = dfp_pkg::CRC_INIT;
      foreach (frame_buf[i]) c = frame_scoreboard::crc_step(c, frame_buf[i]);
      if (corrupt) c = c ^ (16'd1 << $urandom_range(15));
      frame_buf.push_back(c[15:8]);
      frame_buf.push_back(c[7:0]);
   endfunction

   function automatic void commit_frame();
      foreach (frame_buf[i]) stim_bytes.push_back(frame_buf[i]);
      frame_buf.delete();
   endfunction

   function automatic void build_command(logic [7:0] hdr, bit corrupt);
      frame_buf.delete();
      frame_buf.push_back(hdr);
      frame_buf.push_back(dfp_pkg::CMD_SECOND);
      seal_frame(corrupt);
   endfunction

   function automatic void build_block(logic [23:0] idx, logic [7:0] len, bit corrupt);
      frame_buf.delete();
      frame_buf.push_back(dfp_pkg::HDR_DATA);
      frame_buf.push_back(idx[23:16]);
      frame_buf.push_back(idx[15:8]);
      frame_buf.push_back(idx[7:0]);
      repeat (3) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(len);
      for (int i = 0; i < int'(len); i++) frame_buf.push_back(8'($urandom_range(255)));
      seal_frame(corrupt);
   endfunction

   // mostly short payloads; a few long ones and the occasional maximum
   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(199);
      if (r < 1) return 8'd255;
      if (r < 4) return 8'($urandom_range(255, 200));
      if (r < 140) return 8'($urandom_range(6));
      return 8'($urandom_range(40, 7));
   endfunction

   function automatic void add_random_frame();
      int          r;
      int          cut;
      int          full;
      logic [7:0]  len;
      logic [23:0] idx;
      r   = $urandom_range(99);
      len = pick_length();
      if (r < 50) begin
         // in-order block, good CRC
         build_block(next_index, len, 1'b0);
         next_index = next_index + {16'd0, len};
         commit_frame();
      end else if (r < 58) begin
         // corrupted block: expected index must not move
         build_block(next_index, len, 1'b1);
         commit_frame();
      end else if (r < 66) begin
         // out of order, including the all-ones index
         idx = ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom);
         if (idx == next_index) idx = idx ^ 24'h000001;
         build_block(idx, len, 1'b0);
         commit_frame();
      end else if (r < 74) begin
         build_command($urandom_range(1) ? dfp_pkg::HDR_START : dfp_pkg::HDR_END, 1'b0);
         commit_frame();
      end else if (r < 78) begin
         build_command($urandom_range(1) ? dfp_pkg::HDR_START : dfp_pkg::HDR_END, 1'b1);
         commit_frame();
      end else if (r < 83) begin
         // abandoned command; half the time a noise byte other than the second command byte follows
         stim_bytes.push_back($urandom_range(1) ? dfp_pkg::HDR_START : dfp_pkg::HDR_END);
         if ($urandom_range(1)) begin
            do idx[7:0] = noise_byte(); while (idx[7:0] == dfp_pkg::CMD_SECOND);
            stim_bytes.push_back(idx[7:0]);
         end
      end else if (r < 88) begin
         // truncated block; zero fill brings the parser back to hunting
         build_block(next_index, len, 1'b0);
         full = frame_buf.size();
         cut  = $urandom_range(full - 1, 1);
         for (int i = 0; i < cut; i++) stim_bytes.push_back(frame_buf[i]);
         repeat (full - cut) stim_bytes.push_back(8'h00);
         frame_buf.delete();
      end else begin
         repeat ($urandom_range(6, 1)) stim_bytes.push_back(noise_byte());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one word per call, random gap before it
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_stream();
      foreach (stim_bytes[i]) send_byte(stim_bytes[i]);
      stim_bytes.delete();
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both handshakes sampled in one process at each edge so the
   // input is always noted before its result can be checked.
   // ---------------------------------------------------------------------
   initial begin
      dfp_pkg::rsp_word_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_if.valid && req_if.ready) sb.note_byte(req_if.rx_byte);
            if (rsp_if.valid && rsp_if.ready) begin
               got.kind         = rsp_if.kind;
               got.data_byte    = rsp_if.data_byte;
               got.block_index  = rsp_if.block_index;
               got.block_length = rsp_if.block_length;
               sb.check_word(got);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("** download_frame_parser_top: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new;
      sb.clear();
      next_index = '0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: noise extremes, good start, abandoned start whose next
      // byte is 0x02, good end, end with bad CRC, and a zero-length
      // block at index zero right behind an abandoned start
      stim_bytes.push_back(8'h00);
      stim_bytes.push_back(8'hFF);
      build_command(dfp_pkg::HDR_START, 1'b0);
      commit_frame();
      stim_bytes.push_back(dfp_pkg::HDR_START);
      stim_bytes.push_back(8'h02);
      build_command(dfp_pkg::HDR_END, 1'b0);
      commit_frame();
      build_command(dfp_pkg::HDR_END, 1'b1);
      commit_frame();
      stim_bytes.push_back(dfp_pkg::HDR_START);
      build_block(24'h000000, 8'd0, 1'b0);
      commit_frame();

      // phase 1: sender idles a little, receiver stalls a lot
      while (stim_bytes.size() < PHASE_BYTES) add_random_frame();
      send_stream();

      // phase 2: the other way round
      req_idle_pct = 84;
      rsp_idle_pct = 22;
      while (stim_bytes.size() < PHASE_BYTES) add_random_frame();
      send_stream();

      // phase 3: full rate both sides
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (stim_bytes.size() < PHASE_BYTES) add_random_frame();
      send_stream();
      req_if.valid <= 1'b0;

      // drain, then wait out DRAIN_CYCLES for any stray word
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** download_frame_parser_top: PASSED **");
      end else begin
         $display("** download_frame_parser_top: FAILED **");
      end
      $finish;
   end

endmodule

>>> download_frame_parser_top.f
hdl/dfp_pkg.sv
hdl/dfp_if.sv
hdl/dfp_parser.sv
hdl/dfp_out_stage.sv
hdl/download_frame_parser_top.sv
dv/tb_download_frame_parser_top.sv
